@@ hw/rtl/fdc_pkg.sv @@
// Package of the floppy controller command engine: codes, constants and types.
// Used by fdc_core, floppy_controller_command_engine and the testbench; depends on nothing.
package fdc_pkg;

  // Request types carried by one input item.
  localparam logic [2:0] REQ_REG_WR   = 3'd0;
  localparam logic [2:0] REQ_REG_RD   = 3'd1;
  localparam logic [2:0] REQ_DMA_RD   = 3'd2;
  localparam logic [2:0] REQ_DMA_WR   = 3'd3;
  localparam logic [2:0] REQ_CALLBACK = 3'd4;

  // Register offsets from the base address.
  localparam logic [2:0] REG_DOR  = 3'd2;
  localparam logic [2:0] REG_MSR  = 3'd4;
  localparam logic [2:0] REG_FIFO = 3'd5;
  localparam logic [2:0] REG_CCR  = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DENS0 = 2'd0;
  localparam logic [1:0] CFG_DENS1 = 2'd1;
  localparam logic [1:0] CFG_SECS0 = 2'd2;
  localparam logic [1:0] CFG_SECS1 = 2'd3;

  // Command bytes.
  localparam logic [7:0] CMD_SPECIFY   = 8'h03;
  localparam logic [7:0] CMD_SENSE_DRV = 8'h04;
  localparam logic [7:0] CMD_RECAL     = 8'h07;
  localparam logic [7:0] CMD_SENSE_INT = 8'h08;
  localparam logic [7:0] CMD_RDID_FM   = 8'h0A;
  localparam logic [7:0] CMD_DUMPREG   = 8'h0E;
  localparam logic [7:0] CMD_SEEK      = 8'h0F;
  localparam logic [7:0] CMD_CONFIGURE = 8'h13;
  localparam logic [7:0] CMD_WRITE     = 8'h45;
  localparam logic [7:0] CMD_READ      = 8'h46;
  localparam logic [7:0] CMD_RDID_MFM  = 8'h4A;
  localparam logic [7:0] CMD_FORMAT    = 8'h4D;
  localparam logic [7:0] CMD_VERIFY    = 8'h56;

  // Main status values.
  localparam logic [7:0] MSR_RQM    = 8'h80;
  localparam logic [7:0] MSR_CMD    = 8'h90;
  localparam logic [7:0] MSR_RESULT = 8'hD0;
  localparam logic [7:0] MSR_NONDMA = 8'h10;

  // Callback delays in ticks.
  localparam logic [11:0] DLY_100  = 12'd100;
  localparam logic [11:0] DLY_200  = 12'd200;
  localparam logic [11:0] DLY_500  = 12'd500;
  localparam logic [11:0] DLY_1000 = 12'd1000;
  localparam logic [11:0] DLY_2000 = 12'd2000;
  localparam logic [11:0] DLY_4000 = 12'd4000;

  // Phase position marking a terminated write.
  localparam logic [11:0] POS_TERM = 12'd2048;

  // Defaults of the top-level parameters.
  localparam int MAX_PARAMS_DEF   = 10;
  localparam int SECTOR_BYTES_DEF = 1024;

  // One result item.
  typedef struct packed {
    logic [7:0]  bus_read_data;
    logic [11:0] callback_delay;
    logic        irq_line;
    logic        dma_request;
    logic        error_flag;
    logic        store_write;
    logic        store_drive;
    logic        store_head;
    logic [7:0]  store_track;
    logic [7:0]  store_sector;
    logic [9:0]  store_offset;
    logic [7:0]  store_data;
  } fdc_result_t;

endpackage

@@ hw/rtl/floppy_controller_command_engine.sv @@
// Top level of the floppy controller command engine: handshakes and result register.
// Depends on fdc_pkg and fdc_core.
//
// Usage: each input item is one bus event (register write or read, DMA read or
// write, or timer callback). It is accepted when in_valid is high and in_stall
// is low. Exactly one result item follows for every accepted item; it appears
// on the out_ ports in the cycle after acceptance with out_valid high.
// Throughput is one item per cycle while out_stall is low: the whole update
// is done by the engine logic in the accepting cycle and lands in the result
// register. When the receiver raises out_stall the held result stays put and
// in_stall is raised only while that result is still waiting, so a new item is
// taken in the same cycle the old result leaves.
// Configuration (densities and sectors per track) is to be written by the user through
// cfg_we, cfg_index and cfg_wdata while the block is idle; the block does not enforce it.
// Synchronous reset (rst_n low) clears all engine state, sets densities to 2
// and sectors per track to 5, and empties the result register.
module floppy_controller_command_engine #(
  parameter int MAX_PARAMS   = fdc_pkg::MAX_PARAMS_DEF,
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_reg_offset,
  input  logic [7:0]  in_write_data,
  input  logic        in_dma_terminal,
  input  logic [7:0]  in_disc_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_bus_read_data,
  output logic [11:0] out_callback_delay,
  output logic        out_irq_line,
  output logic        out_dma_request,
  output logic        out_error_flag,
  output logic        out_store_write,
  output logic        out_store_drive,
  output logic        out_store_head,
  output logic [7:0]  out_store_track,
  output logic [7:0]  out_store_sector,
  output logic [9:0]  out_store_offset,
  output logic [7:0]  out_store_data
);

  logic                item_take;
  fdc_pkg::fdc_result_t res;
  fdc_pkg::fdc_result_t res_r;
  logic                out_valid_r, out_valid_nxt;

  // An item is taken whenever the result register is free or being emptied.
  assign in_stall  = out_valid_r & out_stall;
  assign item_take = in_valid & ~in_stall;

  fdc_core #(
    .MAX_PARAMS  (MAX_PARAMS),
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .item_take   (item_take),
    .req_type    (in_req_type),
    .reg_offset  (in_reg_offset),
    .write_data  (in_write_data),
    .dma_terminal(in_dma_terminal),
    .disc_byte   (in_disc_byte),
    .result      (res)
  );

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = item_take | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on acceptance.
  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_read_data  = res_r.bus_read_data;
  assign out_callback_delay = res_r.callback_delay;
  assign out_irq_line       = res_r.irq_line;
  assign out_dma_request    = res_r.dma_request;
  assign out_error_flag     = res_r.error_flag;
  assign out_store_write    = res_r.store_write;
  assign out_store_drive    = res_r.store_drive;
  assign out_store_head     = res_r.store_head;
  assign out_store_track    = res_r.store_track;
  assign out_store_sector   = res_r.store_sector;
  assign out_store_offset   = res_r.store_offset;
  assign out_store_data     = res_r.store_data;

`ifndef SYNTHESIS
  // Every accepted item yields a result in the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> out_valid_r)
    else $error("accepted item produced no result");

  // A stalled result is not overwritten.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result changed");

  // A store write addresses a byte inside the sector.
  a_store_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.store_write) |-> (32'(res_r.store_offset) < SECTOR_BYTES))
    else $error("store write beyond sector");
`endif

endmodule

@@ hw/rtl/fdc_core.sv @@
// Command engine state and its single-pass next-state logic of the floppy controller.
// Depends on fdc_pkg; instantiated by floppy_controller_command_engine.
module fdc_core #(
  parameter int MAX_PARAMS   = fdc_pkg::MAX_PARAMS_DEF,
  parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_wdata,
  input  logic                item_take,
  input  logic [2:0]          req_type,
  input  logic [2:0]          reg_offset,
  input  logic [7:0]          write_data,
  input  logic                dma_terminal,
  input  logic [7:0]          disc_byte,
  output fdc_pkg::fdc_result_t result
);

  localparam int          PIDX_W  = $clog2(MAX_PARAMS);
  localparam logic [11:0] POS_SEC = 12'(SECTOR_BYTES);
  localparam logic [11:0] POS_END = 12'(SECTOR_BYTES + 1);

  // Result byte k of the data commands.
  function automatic logic [7:0] res_byte(input logic [11:0] k, input logic [7:0] st0,
                                          input logic [7:0] st1, input logic [7:0] st2,
                                          input logic [7:0] trk, input logic [7:0] p0,
                                          input logic [7:0] sec);
    logic [7:0] b;
    case (k)
      12'd0:   b = st0;
      12'd1:   b = st1;
      12'd2:   b = st2;
      12'd3:   b = trk;
      12'd4:   b = {7'd0, p0[2]};
      12'd5:   b = sec;
      default: b = 8'd3;
    endcase
    return b;
  endfunction

  // Configuration registers.
  logic [1:0] dens_r [2];
  logic [3:0] secs_r [2];

  // Engine state.
  logic        dor2_r, dor2_nxt;
  logic        rst_pend_r, rst_pend_nxt;
  logic [7:0]  msr_r, msr_nxt;
  logic        busy_r, busy_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  st_r [4];
  logic [7:0]  st_nxt [4];
  logic [11:0] pos_r, pos_nxt;
  logic [11:0] saved_r, saved_nxt;
  logic [11:0] dly_r, dly_nxt;
  logic [7:0]  trk_r, trk_nxt;
  logic [7:0]  sec_r, sec_nxt;
  logic        side_r, side_nxt;
  logic [7:0]  fifo_r, fifo_nxt;
  logic [3:0]  ptot_r, ptot_nxt;
  logic [3:0]  pidx_r, pidx_nxt;
  logic [7:0]  prm_r [MAX_PARAMS];
  logic [7:0]  prm_nxt [MAX_PARAMS];
  logic [7:0]  dmab_r, dmab_nxt;
  logic [1:0]  rate_r, rate_nxt;
  logic        irq_r, irq_nxt;
  logic        dreq_r, dreq_nxt;

  // Next state and result of one item.
  always_comb begin
    logic [7:0]  rd;
    logic        err;
    logic        sw;
    logic [9:0]  soff;
    logic [7:0]  sdat;
    logic [3:0]  n;
    logic        known;
    logic [11:0] pos;
    logic [11:0] k;
    logic [3:0]  spt;
    dor2_nxt = dor2_r; rst_pend_nxt = rst_pend_r; msr_nxt = msr_r; busy_nxt = busy_r;
    cmd_nxt = cmd_r; st_nxt = st_r; pos_nxt = pos_r; saved_nxt = saved_r;
    dly_nxt = dly_r; trk_nxt = trk_r; sec_nxt = sec_r; side_nxt = side_r;
    fifo_nxt = fifo_r; ptot_nxt = ptot_r; pidx_nxt = pidx_r; prm_nxt = prm_r;
    dmab_nxt = dmab_r; rate_nxt = rate_r; irq_nxt = irq_r; dreq_nxt = dreq_r;
    rd = 8'd0; err = 1'b0; sw = 1'b0; soff = 10'd0; sdat = 8'd0;
    n = 4'd0; known = 1'b1; pos = pos_r; k = 12'd0; spt = 4'd0;
    case (req_type)
      fdc_pkg::REQ_REG_WR: begin
        case (reg_offset)
          fdc_pkg::REG_DOR: begin
            if (write_data[2] && !dor2_r) begin
              rst_pend_nxt = 1'b1;
              dly_nxt = fdc_pkg::DLY_500;
            end
            if (!write_data[2]) msr_nxt = fdc_pkg::MSR_RQM;
            dor2_nxt = write_data[2];
          end
          fdc_pkg::REG_MSR: ;
          fdc_pkg::REG_CCR: rate_nxt = write_data[1:0];
          fdc_pkg::REG_FIFO: begin
            if (ptot_r != 4'd0) begin
              // Parameter phase.
              if (pidx_r >= ptot_r || 32'(pidx_r) >= MAX_PARAMS) begin
                err = 1'b1;
              end else begin
                prm_nxt[pidx_r[PIDX_W-1:0]] = write_data;
                pidx_nxt = pidx_r + 4'd1;
                if (pidx_nxt == ptot_r) begin
                  msr_nxt = msr_r & 8'h7F;
                  case (cmd_r)
                    fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_SENSE_DRV,
                    fdc_pkg::CMD_CONFIGURE: dly_nxt = fdc_pkg::DLY_100;
                    fdc_pkg::CMD_RECAL, fdc_pkg::CMD_SEEK: begin
                      dly_nxt = fdc_pkg::DLY_500;
                      msr_nxt = msr_nxt | 8'h01;
                    end
                    fdc_pkg::CMD_WRITE, fdc_pkg::CMD_READ, fdc_pkg::CMD_VERIFY: begin
                      pos_nxt = 12'd0;
                      st_nxt[0] = {5'd0, prm_nxt[0][2:0]};
                      st_nxt[1] = 8'd0; st_nxt[2] = 8'd0;
                      dly_nxt = fdc_pkg::DLY_1000;
                      trk_nxt = prm_nxt[1];
                      side_nxt = prm_nxt[2][0];
                      sec_nxt = prm_nxt[3];
                    end
                    fdc_pkg::CMD_RDID_MFM: begin
                      pos_nxt = 12'd0;
                      st_nxt[0] = {5'd0, prm_nxt[0][2:0]};
                      st_nxt[1] = 8'd0; st_nxt[2] = 8'd0;
                      dly_nxt = fdc_pkg::DLY_4000;
                      if (rate_r != dens_r[prm_nxt[0][0]]) cmd_nxt = fdc_pkg::CMD_RDID_FM;
                    end
                    fdc_pkg::CMD_RDID_FM, fdc_pkg::CMD_FORMAT: begin
                      pos_nxt = 12'd0;
                      st_nxt[0] = {5'd0, prm_nxt[0][2:0]};
                      st_nxt[1] = 8'd0; st_nxt[2] = 8'd0;
                      dly_nxt = (cmd_r == fdc_pkg::CMD_FORMAT) ? fdc_pkg::DLY_1000
                                                              : fdc_pkg::DLY_4000;
                    end
                    default: ;
                  endcase
                end
              end
            end else if (busy_r) begin
              err = 1'b1;
            end else begin
              // Command phase.
              case (write_data)
                fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_SEEK: n = 4'd2;
                fdc_pkg::CMD_SENSE_DRV, fdc_pkg::CMD_RECAL, fdc_pkg::CMD_RDID_FM,
                fdc_pkg::CMD_RDID_MFM: n = 4'd1;
                fdc_pkg::CMD_CONFIGURE: n = 4'd3;
                fdc_pkg::CMD_WRITE, fdc_pkg::CMD_READ, fdc_pkg::CMD_VERIFY: n = 4'd8;
                fdc_pkg::CMD_FORMAT: n = 4'd5;
                fdc_pkg::CMD_SENSE_INT, fdc_pkg::CMD_DUMPREG: n = 4'd0;
                default: known = 1'b0;
              endcase
              if (!known) begin
                err = 1'b1;
              end else begin
                busy_nxt = 1'b1;
                pos_nxt = 12'd0;
                cmd_nxt = write_data;
                if (write_data == fdc_pkg::CMD_SENSE_INT) begin
                  dly_nxt = fdc_pkg::DLY_100;
                  msr_nxt = fdc_pkg::MSR_NONDMA;
                end else if (write_data == fdc_pkg::CMD_DUMPREG) begin
                  st_nxt[0] = 8'h80;
                  fifo_nxt = 8'h80;
                  irq_nxt = 1'b1;
                  busy_nxt = 1'b0;
                  dly_nxt = 12'd0;
                  msr_nxt = fdc_pkg::MSR_RQM;
                end else begin
                  ptot_nxt = n;
                  pidx_nxt = 4'd0;
                  msr_nxt = (write_data == fdc_pkg::CMD_FORMAT) ? fdc_pkg::MSR_RQM
                                                                : fdc_pkg::MSR_CMD;
                end
              end
            end
          end
          default: err = 1'b1;
        endcase
      end
      fdc_pkg::REQ_REG_RD: begin
        if (reg_offset == fdc_pkg::REG_MSR) begin
          irq_nxt = 1'b0;
          rd = msr_r;
        end else if (reg_offset == fdc_pkg::REG_FIFO) begin
          msr_nxt = busy_r ? (msr_r & 8'h7F) : fdc_pkg::MSR_RQM;
          if (busy_r) dly_nxt = fdc_pkg::DLY_100;
          rd = fifo_r;
        end else begin
          err = 1'b1;
        end
      end
      fdc_pkg::REQ_DMA_RD: begin
        dreq_nxt = 1'b0;
        dly_nxt = (pos_r != 12'd0) ? fdc_pkg::DLY_100 : fdc_pkg::DLY_2000;
        if (dma_terminal) begin
          pos_nxt = POS_SEC;
          dly_nxt = fdc_pkg::DLY_2000;
          st_nxt[0] = 8'd0;
        end
        rd = dmab_r;
      end
      fdc_pkg::REQ_DMA_WR: begin
        dreq_nxt = 1'b0;
        dly_nxt = (pos_r != 12'd0) ? fdc_pkg::DLY_200 : fdc_pkg::DLY_2000;
        if (dma_terminal) begin
          saved_nxt = pos_r;
          pos_nxt = fdc_pkg::POS_TERM;
          dly_nxt = fdc_pkg::DLY_2000;
          st_nxt[0] = 8'd0;
        end
        dmab_nxt = write_data;
      end
      fdc_pkg::REQ_CALLBACK: begin
        dly_nxt = 12'd0;
        if (rst_pend_r) begin
          // Controller reset completes.
          irq_nxt = 1'b1; rst_pend_nxt = 1'b0; msr_nxt = fdc_pkg::MSR_RQM;
          busy_nxt = 1'b0; st_nxt[0] = 8'hC0; trk_nxt = 8'd0;
          ptot_nxt = 4'd0; pidx_nxt = 4'd0; rate_nxt = 2'd2;
        end else begin
          case (cmd_r)
            fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_CONFIGURE: begin
              busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
              msr_nxt = fdc_pkg::MSR_RQM;
            end
            fdc_pkg::CMD_SENSE_DRV: begin
              st_nxt[3] = {2'b00, 1'b1, (trk_r == 8'd0), 1'b1, prm_r[0][2:0]};
              busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
              fifo_nxt = st_nxt[3]; msr_nxt = fdc_pkg::MSR_RESULT; irq_nxt = 1'b1;
            end
            fdc_pkg::CMD_RECAL, fdc_pkg::CMD_SEEK: begin
              trk_nxt = (cmd_r == fdc_pkg::CMD_RECAL) ? 8'd0 : prm_r[1];
              busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
              msr_nxt = fdc_pkg::MSR_RQM; irq_nxt = 1'b1; st_nxt[0] = 8'h20;
            end
            fdc_pkg::CMD_SENSE_INT: begin
              pos_nxt = (pos < 12'd2) ? pos + 12'd1 : 12'd2;
              msr_nxt = fdc_pkg::MSR_RESULT; irq_nxt = 1'b1;
              if (pos_nxt == 12'd1) begin
                fifo_nxt = st_r[0];
                dly_nxt = fdc_pkg::DLY_100;
              end else begin
                busy_nxt = 1'b0;
                fifo_nxt = trk_r;
              end
            end
            fdc_pkg::CMD_WRITE: begin
              if (pos == fdc_pkg::POS_TERM) begin
                // Final byte of a terminated write.
                if (saved_r >= 12'd1 && saved_r <= POS_SEC) begin
                  sw = 1'b1; soff = 10'(saved_r - 12'd1); sdat = dmab_r;
                end
                pos_nxt = POS_END;
                dly_nxt = fdc_pkg::DLY_500;
                sec_nxt = sec_r + 8'd1;
              end else if (pos >= POS_END) begin
                k = pos - POS_END;
                if (k <= 12'd6) begin
                  fifo_nxt = res_byte(k, st_r[0], st_r[1], st_r[2], trk_r, prm_r[0], sec_r);
                  msr_nxt = fdc_pkg::MSR_RESULT;
                  if (k == 12'd0) irq_nxt = 1'b1;
                  if (k == 12'd6) begin
                    busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
                  end
                  pos_nxt = pos + 12'd1;
                end
              end else begin
                if (pos != 12'd0) begin
                  sw = 1'b1; soff = 10'(pos - 12'd1); sdat = dmab_r;
                end
                if (pos + 12'd1 == POS_END) begin
                  sec_nxt = sec_r + 8'd1;
                  pos_nxt = (sec_nxt <= prm_r[5]) ? 12'd0 : POS_END;
                  dly_nxt = fdc_pkg::DLY_100;
                end else begin
                  pos_nxt = pos + 12'd1;
                  dreq_nxt = 1'b1;
                end
              end
            end
            fdc_pkg::CMD_READ: begin
              if (pos >= POS_SEC) begin
                k = pos - POS_SEC;
                if (k <= 12'd6) begin
                  fifo_nxt = res_byte(k, st_r[0], st_r[1], st_r[2], trk_r, prm_r[0], sec_r);
                  msr_nxt = fdc_pkg::MSR_RESULT;
                  if (k == 12'd0) irq_nxt = 1'b1;
                  if (k == 12'd6) begin
                    busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
                  end
                  pos_nxt = pos + 12'd1;
                end
              end else begin
                dmab_nxt = disc_byte;
                dreq_nxt = 1'b1;
                pos_nxt = pos + 12'd1;
                if (pos_nxt == POS_SEC) begin
                  sec_nxt = sec_r + 8'd1;
                  if (sec_nxt <= prm_r[5]) pos_nxt = 12'd0;
                end
              end
            end
            fdc_pkg::CMD_RDID_MFM: begin
              spt = secs_r[st_r[0][0]];
              if (sec_r >= {4'd0, spt}) sec_nxt = 8'd0;
              if (pos <= 12'd6) begin
                fifo_nxt = res_byte(pos, st_r[0], st_r[1], st_r[2], trk_r, prm_r[0],
                                    sec_nxt);
                msr_nxt = fdc_pkg::MSR_RESULT;
                if (pos == 12'd0) irq_nxt = 1'b1;
                pos_nxt = pos + 12'd1;
                if (pos_nxt == 12'd7) begin
                  busy_nxt = 1'b0;
                  sec_nxt = (sec_nxt + 8'd1 >= {4'd0, spt}) ? 8'd0 : sec_nxt + 8'd1;
                  ptot_nxt = 4'd0; pidx_nxt = 4'd0;
                end
              end
            end
            fdc_pkg::CMD_RDID_FM: begin
              irq_nxt = 1'b1;
              st_nxt[0] = {5'b01000, prm_r[0][2:0]};
              st_nxt[1] = 8'd1; st_nxt[2] = 8'd1;
              busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
            end
            fdc_pkg::CMD_FORMAT: begin
              if (pos <= 12'd6) begin
                fifo_nxt = (pos <= 12'd2)
                  ? res_byte(pos, st_r[0], st_r[1], st_r[2], trk_r, prm_r[0], sec_r)
                  : 8'd0;
                msr_nxt = fdc_pkg::MSR_RESULT;
                if (pos == 12'd0) irq_nxt = 1'b1;
                if (pos == 12'd6) begin
                  busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
                end
                pos_nxt = pos + 12'd1;
              end
            end
            fdc_pkg::CMD_VERIFY: begin
              sec_nxt = prm_r[0][7] ? prm_r[7] : prm_r[5];
              if (pos <= 12'd6) begin
                fifo_nxt = res_byte(pos, st_r[0], st_r[1], st_r[2], trk_r, prm_r[0],
                                    sec_nxt);
                msr_nxt = fdc_pkg::MSR_RESULT;
                if (pos == 12'd0) irq_nxt = 1'b1;
                if (pos == 12'd6) begin
                  busy_nxt = 1'b0; ptot_nxt = 4'd0; pidx_nxt = 4'd0;
                end
                pos_nxt = pos + 12'd1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Store offset follows the phase position when nothing is written.
    if (!sw) soff = (pos_nxt < POS_SEC) ? pos_nxt[9:0] : 10'd0;

    result.bus_read_data  = rd;
    result.callback_delay = dly_nxt;
    result.irq_line       = irq_nxt;
    result.dma_request    = dreq_nxt;
    result.error_flag     = err;
    result.store_write    = sw;
    result.store_drive    = prm_nxt[0][0];
    result.store_head     = side_nxt;
    result.store_track    = trk_nxt;
    result.store_sector   = sec_nxt;
    result.store_offset   = soff;
    result.store_data     = sdat;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dens_r[0] <= 2'd2; dens_r[1] <= 2'd2;
      secs_r[0] <= 4'd5; secs_r[1] <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        fdc_pkg::CFG_DENS0: dens_r[0] <= cfg_wdata[1:0];
        fdc_pkg::CFG_DENS1: dens_r[1] <= cfg_wdata[1:0];
        fdc_pkg::CFG_SECS0: secs_r[0] <= cfg_wdata;
        fdc_pkg::CFG_SECS1: secs_r[1] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Engine state update on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dor2_r <= 1'b0; rst_pend_r <= 1'b0; msr_r <= 8'd0; busy_r <= 1'b0;
      cmd_r <= 8'd0; st_r <= '{default: 8'd0}; pos_r <= 12'd0; saved_r <= 12'd0;
      dly_r <= 12'd0; trk_r <= 8'd0; sec_r <= 8'd0; side_r <= 1'b0; fifo_r <= 8'd0;
      ptot_r <= 4'd0; pidx_r <= 4'd0; prm_r <= '{default: 8'd0}; dmab_r <= 8'd0;
      rate_r <= 2'd0; irq_r <= 1'b0; dreq_r <= 1'b0;
    end else if (item_take) begin
      dor2_r <= dor2_nxt; rst_pend_r <= rst_pend_nxt; msr_r <= msr_nxt;
      busy_r <= busy_nxt; cmd_r <= cmd_nxt; st_r <= st_nxt; pos_r <= pos_nxt;
      saved_r <= saved_nxt; dly_r <= dly_nxt; trk_r <= trk_nxt; sec_r <= sec_nxt;
      side_r <= side_nxt; fifo_r <= fifo_nxt; ptot_r <= ptot_nxt; pidx_r <= pidx_nxt;
      prm_r <= prm_nxt; dmab_r <= dmab_nxt; rate_r <= rate_nxt; irq_r <= irq_nxt;
      dreq_r <= dreq_nxt;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of floppy_controller_command_engine: stimulus, prediction, checks.
// Depends on fdc_pkg and the RTL of the command engine; reads nothing else.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Request type the block does not know, and a command byte it rejects.
  localparam logic [2:0] REQ_UNKNOWN = 3'd5;
  localparam logic [7:0] CMD_BAD     = 8'hFF;
  localparam logic [7:0] DOR_RESET   = 8'h04;
  localparam logic [11:0] POS_END    = 12'd1025;
  localparam logic [11:0] SECTOR_LEN = 12'd1024;
  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [2:0] req;
    logic [2:0] off;
    logic [7:0] wd;
    logic       term;
    logic [7:0] disc;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [2:0] in_reg_offset = '0;
  logic [7:0] in_write_data = '0;
  logic in_dma_terminal = 1'b0;
  logic [7:0] in_disc_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wire fdc_pkg::fdc_result_t got;

  floppy_controller_command_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_reg_offset(in_reg_offset),
    .in_write_data(in_write_data), .in_dma_terminal(in_dma_terminal),
    .in_disc_byte(in_disc_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bus_read_data(got.bus_read_data), .out_callback_delay(got.callback_delay),
    .out_irq_line(got.irq_line), .out_dma_request(got.dma_request),
    .out_error_flag(got.error_flag), .out_store_write(got.store_write),
    .out_store_drive(got.store_drive), .out_store_head(got.store_head),
    .out_store_track(got.store_track), .out_store_sector(got.store_sector),
    .out_store_offset(got.store_offset), .out_store_data(got.store_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  bus_item_t            pending_items[$];
  fdc_pkg::fdc_result_t expected_results[$];
  int  cycle = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  failed = 1'b0;

  // Own copy of the controller state.
  logic [7:0]  dor_q, msr_q, cmd_q, track_q, sector_q, side_q, fifo_q, dmab_q;
  logic [7:0]  st_q[4];
  logic [7:0]  pb_q[10];
  logic        rst_pend_q, busy_q, irq_q, dreq_q;
  logic [3:0]  ptot_q, pidx_q;
  logic [11:0] pos_q, saved_q, delay_q;
  logic [1:0]  rate_q;
  logic [1:0]  dens_q[2];
  logic [3:0]  secs_q[2];
  // Store access of the current item.
  logic        sw_q;
  logic [11:0] soff_q;
  logic [7:0]  sdata_q;

  task automatic clear_model();
    dor_q = '0; msr_q = '0; cmd_q = '0; track_q = '0; sector_q = '0; side_q = '0;
    fifo_q = '0; dmab_q = '0; rst_pend_q = 0; busy_q = 0; irq_q = 0; dreq_q = 0;
    ptot_q = '0; pidx_q = '0; pos_q = '0; saved_q = '0; delay_q = '0; rate_q = '0;
    foreach (st_q[i]) st_q[i] = '0;
    foreach (pb_q[i]) pb_q[i] = '0;
    dens_q[0] = 2'd2; dens_q[1] = 2'd2; secs_q[0] = 4'd5; secs_q[1] = 4'd5;
  endtask

  function automatic void put_fifo(input logic [7:0] v, input bit irq);
    fifo_q = v;
    msr_q = fdc_pkg::MSR_RESULT;
    if (irq) irq_q = 1'b1;
  endfunction

  function automatic void finish_command();
    busy_q = 0; ptot_q = '0; pidx_q = '0;
  endfunction

  // Result bytes of the data commands.
  function automatic void put_result(input int k);
    case (k)
      0: put_fifo(st_q[0], 1'b1);
      1: put_fifo(st_q[1], 1'b0);
      2: put_fifo(st_q[2], 1'b0);
      3: put_fifo(track_q, 1'b0);
      4: put_fifo(pb_q[0][2] ? 8'd1 : 8'd0, 1'b0);
      5: put_fifo(sector_q, 1'b0);
      default: put_fifo(8'd3, 1'b0);
    endcase
  endfunction

  function automatic void store_byte(input logic [11:0] o);
    sw_q = 1'b1; soff_q = o; sdata_q = dmab_q;
  endfunction

  function automatic void begin_transfer();
    pos_q = '0;
    st_q[0] = {5'd0, pb_q[0][2:0]};
    st_q[1] = '0;
    st_q[2] = '0;
  endfunction

  function automatic void params_complete();
    msr_q &= 8'h7F;
    case (cmd_q)
      fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_SENSE_DRV, fdc_pkg::CMD_CONFIGURE:
        delay_q = fdc_pkg::DLY_100;
      fdc_pkg::CMD_RECAL, fdc_pkg::CMD_SEEK: begin
        delay_q = fdc_pkg::DLY_500;
        msr_q |= 8'h01;
      end
      fdc_pkg::CMD_WRITE, fdc_pkg::CMD_READ, fdc_pkg::CMD_VERIFY: begin
        begin_transfer();
        delay_q = fdc_pkg::DLY_1000;
        track_q = pb_q[1]; side_q = pb_q[2]; sector_q = pb_q[3];
      end
      fdc_pkg::CMD_RDID_MFM: begin
        begin_transfer();
        delay_q = fdc_pkg::DLY_4000;
        if (rate_q != dens_q[st_q[0][0]]) cmd_q = fdc_pkg::CMD_RDID_FM;
      end
      fdc_pkg::CMD_RDID_FM: begin
        begin_transfer();
        delay_q = fdc_pkg::DLY_4000;
      end
      fdc_pkg::CMD_FORMAT: begin
        begin_transfer();
        delay_q = fdc_pkg::DLY_1000;
      end
      default: ;
    endcase
  endfunction

  function automatic int param_count(input logic [7:0] c);
    case (c)
      fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_SEEK: return 2;
      fdc_pkg::CMD_SENSE_DRV, fdc_pkg::CMD_RECAL, fdc_pkg::CMD_RDID_FM,
      fdc_pkg::CMD_RDID_MFM: return 1;
      fdc_pkg::CMD_CONFIGURE: return 3;
      fdc_pkg::CMD_WRITE, fdc_pkg::CMD_READ, fdc_pkg::CMD_VERIFY: return 8;
      fdc_pkg::CMD_FORMAT: return 5;
      fdc_pkg::CMD_SENSE_INT, fdc_pkg::CMD_DUMPREG: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic void fifo_written(input logic [7:0] v, output bit err);
    int n;
    err = 0;
    if (ptot_q != 0) begin
      if (pidx_q >= ptot_q || pidx_q >= 10) begin
        err = 1;
        return;
      end
      pb_q[pidx_q] = v;
      pidx_q++;
      if (pidx_q == ptot_q) params_complete();
      return;
    end
    n = param_count(v);
    if (busy_q || n < 0) begin
      err = 1;
      return;
    end
    busy_q = 1; pos_q = '0; cmd_q = v;
    if (v == fdc_pkg::CMD_SENSE_INT) begin
      delay_q = fdc_pkg::DLY_100;
      msr_q = fdc_pkg::MSR_NONDMA;
    end else if (v == fdc_pkg::CMD_DUMPREG) begin
      st_q[0] = 8'h80;
      put_fifo(8'h80, 1'b1);
      busy_q = 0; delay_q = '0; msr_q = fdc_pkg::MSR_RQM;
    end else begin
      ptot_q = n[3:0]; pidx_q = '0;
      msr_q = (v == fdc_pkg::CMD_FORMAT) ? fdc_pkg::MSR_RQM : fdc_pkg::MSR_CMD;
    end
  endfunction

  function automatic void timer_fired(input logic [7:0] disc);
    logic [11:0] p;
    int k;
    p = pos_q;
    delay_q = '0;
    if (rst_pend_q) begin
      irq_q = 1; rst_pend_q = 0; msr_q = fdc_pkg::MSR_RQM; busy_q = 0; st_q[0] = 8'hC0;
      track_q = '0; ptot_q = '0; pidx_q = '0; rate_q = 2'd2;
      return;
    end
    case (cmd_q)
      fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_CONFIGURE: begin
        finish_command();
        msr_q = fdc_pkg::MSR_RQM;
      end
      fdc_pkg::CMD_SENSE_DRV: begin
        st_q[3] = {5'd0, pb_q[0][2:0]} | 8'h28;
        if (track_q == 0) st_q[3] |= 8'h10;
        finish_command();
        put_fifo(st_q[3], 1'b1);
      end
      fdc_pkg::CMD_RECAL, fdc_pkg::CMD_SEEK: begin
        track_q = (cmd_q == fdc_pkg::CMD_RECAL) ? 8'd0 : pb_q[1];
        finish_command();
        msr_q = fdc_pkg::MSR_RQM; irq_q = 1; st_q[0] = 8'h20;
      end
      fdc_pkg::CMD_SENSE_INT: begin
        pos_q = (p < 12'd2) ? p + 12'd1 : 12'd2;
        if (pos_q == 12'd1) begin
          put_fifo(st_q[0], 1'b1);
          delay_q = fdc_pkg::DLY_100;
        end else begin
          busy_q = 0;
          put_fifo(track_q, 1'b1);
        end
      end
      fdc_pkg::CMD_WRITE: begin
        if (p == fdc_pkg::POS_TERM) begin
          if (saved_q >= 12'd1 && saved_q <= SECTOR_LEN) store_byte(saved_q - 12'd1);
          pos_q = POS_END; delay_q = fdc_pkg::DLY_500; sector_q++;
        end else if (p >= POS_END) begin
          k = int'(p - POS_END);
          if (k <= 6) begin
            put_result(k);
            if (k == 6) begin
              finish_command();
              delay_q = '0;
            end
            pos_q = p + 12'd1;
          end
        end else begin
          if (p != 0) store_byte(p - 12'd1);
          p++;
          if (p == POS_END) begin
            sector_q++;
            pos_q = (sector_q <= pb_q[5]) ? 12'd0 : p;
            delay_q = fdc_pkg::DLY_100;
          end else begin
            pos_q = p;
            dreq_q = 1;
          end
        end
      end
      fdc_pkg::CMD_READ: begin
        if (p >= SECTOR_LEN) begin
          k = int'(p - SECTOR_LEN);
          if (k <= 6) begin
            put_result(k);
            if (k == 6) finish_command();
            pos_q = p + 12'd1;
          end
        end else begin
          dmab_q = disc; dreq_q = 1;
          p++;
          if (p == SECTOR_LEN) begin
            sector_q++;
            if (sector_q <= pb_q[5]) p = '0;
          end
          pos_q = p;
        end
      end
      fdc_pkg::CMD_RDID_MFM: begin
        if (sector_q >= {4'd0, secs_q[st_q[0][0]]}) sector_q = '0;
        if (p <= 12'd6) begin
          put_result(int'(p));
          pos_q = p + 12'd1;
          if (pos_q == 12'd7) begin
            busy_q = 0;
            sector_q++;
            if (sector_q >= {4'd0, secs_q[st_q[0][0]]}) sector_q = '0;
            ptot_q = '0; pidx_q = '0;
          end
        end
      end
      fdc_pkg::CMD_RDID_FM: begin
        irq_q = 1;
        st_q[0] = 8'h40 | {5'd0, pb_q[0][2:0]};
        st_q[1] = 8'd1; st_q[2] = 8'd1;
        finish_command();
      end
      fdc_pkg::CMD_FORMAT: begin
        if (p <= 12'd6) begin
          if (p <= 12'd2) put_result(int'(p));
          else put_fifo(8'd0, 1'b0);
          if (p == 12'd6) finish_command();
          pos_q = p + 12'd1;
        end
      end
      fdc_pkg::CMD_VERIFY: begin
        sector_q = pb_q[0][7] ? pb_q[7] : pb_q[5];
        if (p <= 12'd6) begin
          put_result(int'(p));
          if (p == 12'd6) finish_command();
          pos_q = p + 12'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted item and advances the state copy.
  function automatic fdc_pkg::fdc_result_t controller_step(input bus_item_t it);
    fdc_pkg::fdc_result_t r;
    bit err;
    r = '0; err = 0;
    sw_q = 0; soff_q = '0; sdata_q = '0;
    case (it.req)
      fdc_pkg::REQ_REG_WR: begin
        case (it.off)
          fdc_pkg::REG_DOR: begin
            if (it.wd[2] && !dor_q[2]) begin
              rst_pend_q = 1;
              delay_q = fdc_pkg::DLY_500;
            end
            if (!it.wd[2]) msr_q = fdc_pkg::MSR_RQM;
            dor_q = it.wd;
          end
          fdc_pkg::REG_MSR: ;
          fdc_pkg::REG_FIFO: fifo_written(it.wd, err);
          fdc_pkg::REG_CCR: rate_q = it.wd[1:0];
          default: err = 1;
        endcase
      end
      fdc_pkg::REQ_REG_RD: begin
        if (it.off == fdc_pkg::REG_MSR) begin
          irq_q = 0;
          r.bus_read_data = msr_q;
        end else if (it.off == fdc_pkg::REG_FIFO) begin
          msr_q &= 8'h7F;
          if (!busy_q) msr_q = fdc_pkg::MSR_RQM;
          else delay_q = fdc_pkg::DLY_100;
          r.bus_read_data = fifo_q;
        end else begin
          err = 1;
        end
      end
      fdc_pkg::REQ_DMA_RD: begin
        dreq_q = 0;
        delay_q = (pos_q != 0) ? fdc_pkg::DLY_100 : fdc_pkg::DLY_2000;
        if (it.term) begin
          pos_q = SECTOR_LEN; delay_q = fdc_pkg::DLY_2000; st_q[0] = '0;
        end
        r.bus_read_data = dmab_q;
      end
      fdc_pkg::REQ_DMA_WR: begin
        dreq_q = 0;
        delay_q = (pos_q != 0) ? fdc_pkg::DLY_200 : fdc_pkg::DLY_2000;
        if (it.term) begin
          saved_q = pos_q; pos_q = fdc_pkg::POS_TERM; delay_q = fdc_pkg::DLY_2000;
          st_q[0] = '0;
        end
        dmab_q = it.wd;
      end
      fdc_pkg::REQ_CALLBACK: timer_fired(it.disc);
      default: ;
    endcase
    if (!sw_q) soff_q = (pos_q < SECTOR_LEN) ? pos_q : 12'd0;
    r.callback_delay = delay_q;
    r.irq_line = irq_q;
    r.dma_request = dreq_q;
    r.error_flag = err;
    r.store_write = sw_q;
    r.store_drive = pb_q[0][0];
    r.store_head = side_q[0];
    r.store_track = track_q;
    r.store_sector = sector_q;
    r.store_offset = soff_q[9:0];
    r.store_data = sdata_q;
    return r;
  endfunction

  function automatic bit idle_now();
    return (cycle < 5000 || cycle > 9000) && ($urandom_range(99) < 36);
  endfunction

  // Driver: offers pending items and predicts each one at acceptance.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(controller_step({
          in_req_type, in_reg_offset, in_write_data, in_dma_terminal, in_disc_byte}));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !idle_now()) begin
          bus_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_req_type <= it.req; in_reg_offset <= it.off; in_write_data <= it.wd;
          in_dma_terminal <= it.term; in_disc_byte <= it.disc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, so that the block fills and stalls its input.
  always @(posedge clk) begin
    if (cycle == 2500) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic check_field(input string name, input logic [11:0] e, input logic [11:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failed = 1'b1;
    end
  endtask

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= (hold_left > 1) || idle_now();
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          failed = 1'b1;
        end else begin
          fdc_pkg::fdc_result_t e;
          e = expected_results.pop_front();
          check_field("bus_read_data", 12'(e.bus_read_data), 12'(got.bus_read_data));
          check_field("callback_delay", e.callback_delay, got.callback_delay);
          check_field("irq_line", 12'(e.irq_line), 12'(got.irq_line));
          check_field("dma_request", 12'(e.dma_request), 12'(got.dma_request));
          check_field("error_flag", 12'(e.error_flag), 12'(got.error_flag));
          check_field("store_write", 12'(e.store_write), 12'(got.store_write));
          check_field("store_drive", 12'(e.store_drive), 12'(got.store_drive));
          check_field("store_head", 12'(e.store_head), 12'(got.store_head));
          check_field("store_track", 12'(e.store_track), 12'(got.store_track));
          check_field("store_sector", 12'(e.store_sector), 12'(got.store_sector));
          check_field("store_offset", 12'(e.store_offset), 12'(got.store_offset));
          check_field("store_data", 12'(e.store_data), 12'(got.store_data));
        end
      end
    end
  end

  // Watchdog on cycles in which neither side accepts anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n ||
        (pending_items.size() == 0 && expected_results.size() == 0))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic add_item(input logic [2:0] req, input logic [2:0] off,
                          input logic [7:0] wd, input logic term);
    bus_item_t it;
    it.req = req; it.off = off; it.wd = wd; it.term = term;
    it.disc = 8'($urandom_range(255));
    pending_items.push_back(it);
  endtask

  task automatic add_callbacks(input int n);
    repeat (n) add_item(fdc_pkg::REQ_CALLBACK, '0, '0, 1'b0);
  endtask

  // Command byte followed by its parameter bytes.
  task automatic add_command(input logic [7:0] c);
    logic [7:0] p[10];
    int n;
    n = param_count(c);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, c, 1'b0);
    foreach (p[i]) p[i] = 8'($urandom_range(255));
    p[3] = 8'($urandom_range(3));
    p[5] = p[3] + 8'($urandom_range(1));
    for (int i = 0; i < n; i++) add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, p[i], 1'b0);
  endtask

  // One command, well-formed or the rejected CMD_BAD, with a random body of traffic, or pure noise.
  task automatic add_sequence();
    logic [7:0] cmds[14];
    logic [7:0] c;
    int len, sel;
    cmds = '{fdc_pkg::CMD_SPECIFY, fdc_pkg::CMD_SENSE_DRV, fdc_pkg::CMD_RECAL,
             fdc_pkg::CMD_SENSE_INT, fdc_pkg::CMD_RDID_FM, fdc_pkg::CMD_DUMPREG,
             fdc_pkg::CMD_SEEK, fdc_pkg::CMD_CONFIGURE, fdc_pkg::CMD_WRITE,
             fdc_pkg::CMD_READ, fdc_pkg::CMD_RDID_MFM, fdc_pkg::CMD_FORMAT,
             fdc_pkg::CMD_VERIFY, CMD_BAD};
    len = $urandom_range(4, 30);
    if ($urandom_range(9) == 0) begin
      repeat (len) add_item(3'($urandom_range(7)), 3'($urandom_range(7)),
                            8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    c = cmds[$urandom_range(13)];
    add_command(c);
    repeat (len) begin
      sel = $urandom_range(99);
      if (sel < 45) add_callbacks(1);
      else if (sel < 75)
        add_item(c == fdc_pkg::CMD_WRITE ? fdc_pkg::REQ_DMA_WR : fdc_pkg::REQ_DMA_RD,
                 3'($urandom_range(7)), 8'($urandom_range(255)), $urandom_range(9) == 0);
      else if (sel < 85)
        add_item(fdc_pkg::REQ_REG_RD, fdc_pkg::REG_MSR, 8'($urandom_range(255)), 1'b0);
      else if (sel < 95)
        add_item(fdc_pkg::REQ_REG_RD, fdc_pkg::REG_FIFO, 8'($urandom_range(255)), 1'b0);
      else if (sel < 97)
        add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_CCR, 8'($urandom_range(255)), 1'b0);
      else if (sel < 98)
        add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, 8'($urandom_range(255)), 1'b0);
      else begin
        add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_DOR, 8'h00, 1'b0);
        add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_DOR,
                 8'($urandom_range(255)) | DOR_RESET, 1'b0);
        add_callbacks(1);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_settings(input logic [1:0] d0, input logic [1:0] d1,
                                input logic [3:0] s0, input logic [3:0] s1);
    logic [3:0] vals[4];
    vals = '{{2'b0, d0}, {2'b0, d1}, s0, s1};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1; cfg_index <= i[1:0]; cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    dens_q[0] = d0; dens_q[1] = d1; secs_q[0] = s0; secs_q[1] = s1;
  endtask

  initial begin
    clear_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: DOR reset edge, unknown registers and types, the rejected byte and five commands.
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_DOR, 8'h00, 1'b0);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_DOR, 8'hFF, 1'b0);
    add_callbacks(1);
    add_item(fdc_pkg::REQ_REG_WR, 3'd0, 8'hFF, 1'b0);
    add_item(fdc_pkg::REQ_REG_RD, 3'd7, 8'h00, 1'b0);
    add_item(REQ_UNKNOWN, fdc_pkg::REG_FIFO, 8'hFF, 1'b1);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, CMD_BAD, 1'b0);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, fdc_pkg::CMD_SENSE_INT, 1'b0);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, fdc_pkg::CMD_SPECIFY, 1'b0);
    add_callbacks(4);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, fdc_pkg::CMD_DUMPREG, 1'b0);
    add_item(fdc_pkg::REQ_REG_RD, fdc_pkg::REG_FIFO, 8'h00, 1'b0);
    add_command(fdc_pkg::CMD_WRITE);
    add_callbacks(1);
    add_item(fdc_pkg::REQ_DMA_WR, fdc_pkg::REG_FIFO, 8'hFF, 1'b1);
    add_callbacks(9);
    add_item(fdc_pkg::REQ_REG_WR, fdc_pkg::REG_FIFO, fdc_pkg::CMD_SEEK, 1'b0);
    wait_drained();

    // Phases under three settings, the density extremes among them.
    write_settings(2'd0, 2'd3, 4'd1, 4'd10);
    for (int n = 0; n < 280; n = pending_items.size()) add_sequence();
    wait_drained();
    write_settings(2'd3, 2'd0, 4'd10, 4'd1);
    for (int n = 0; n < 280; n = pending_items.size()) add_sequence();
    wait_drained();
    write_settings(2'd2, 2'd1, 4'd5, 4'd7);
    for (int n = 0; n < 280; n = pending_items.size()) add_sequence();
    wait_drained();

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_core.sv
hw/rtl/floppy_controller_command_engine.sv
tb/testbench.sv
